FILE: rtl/core/beacon_table_with_weakest_eviction_macros.svh
// assertion macros for the beacon table
`ifndef BEACON_TABLE_WITH_WEAKEST_EVICTION_MACROS_SVH
`define BEACON_TABLE_WITH_WEAKEST_EVICTION_MACROS_SVH

// property must hold at every clock edge out of reset
`define BTW_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// condition must never be true out of reset
`define BTW_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

FILE: rtl/core/btw_pkg.sv
// shared types and constants for the beacon table
package btw_pkg;

  localparam int TableEntries = 32;
  localparam int IdxW = $clog2(TableEntries);
  localparam int CntW = $clog2(TableEntries + 1);

  localparam int InDataW  = 152;
  localparam int OutDataW = 120;

  localparam logic [1:0] ModeObserve = 2'd0;
  localparam logic [1:0] ModePurge   = 2'd1;
  localparam logic [1:0] ModeRead    = 2'd2;
  localparam logic [1:0] ModeNop     = 2'd3;

  localparam logic [31:0] PurgeReset = 32'd30000000;

  typedef struct packed {
    logic [47:0] ts;
    logic [2:0]  sec;
    logic [15:0] cap;
    logic [15:0] per;
    logic [7:0]  sig;
    logic [7:0]  chan;
    logic [47:0] addr;
  } entry_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [47:0] now;
    logic [4:0]  read_slot;
    entry_t      ent;
  } req_t;

  typedef struct packed {
    logic            capture;
    logic            rd_en;
    logic            eval;
    logic            write;
    logic [IdxW-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
  } sts_t;

endpackage

FILE: rtl/core/btw_ctrl.sv
// sequencer for table scans, writes and result handoff
module btw_ctrl import btw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StIssue = 3'd1;
  localparam logic [2:0] StEval  = 3'd2;
  localparam logic [2:0] StWrite = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    cmd_o         = '0;
    cmd_o.idx     = idx_q;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          idx_d         = '0;
          state_d       = StIssue;
        end
      end
      StIssue: begin
        cmd_o.rd_en = 1'b1;
        state_d     = StEval;
      end
      StEval: begin
        cmd_o.eval = 1'b1;
        if (sts_i.mode inside {ModeRead, ModeNop}) begin
          state_d = StOut;
        end else if (idx_q == IdxW'(TableEntries - 1)) begin
          state_d = (sts_i.mode == ModeObserve) ? StWrite : StOut;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = StIssue;
        end
      end
      StWrite: begin
        cmd_o.write = 1'b1;
        state_d     = StOut;
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

FILE: rtl/core/btw_dp.sv
// record memory, valid marks, scan trackers and result register
module btw_dp import btw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic [InDataW-1:0]  in_data_i,
  input  logic [1:0]          in_mode_i,
  output logic [OutDataW-1:0] out_data_o,
  output logic [CntW-1:0]     live_o
);

  req_t                   req_q;
  entry_t                 mem_q [TableEntries];
  entry_t                 rd_q;
  logic [TableEntries-1:0] valid_q;
  logic [CntW-1:0]        live_q, purged_q;
  logic [31:0]            interval_q;

  logic            found_q, free_q;
  logic [IdxW-1:0] hit_slot_q, free_slot_q, min_slot_q;
  logic [7:0]      min_sig_q;

  logic [4:0]  res_slot_q;
  logic        res_present_q, res_replaced_q, res_ev_q;
  entry_t      res_ent_q;

  logic [IdxW-1:0] rs_idx, rd_addr, wslot;
  logic            rs_ok, cur_valid, stale;
  logic [47:0]     age;
  entry_t          wentry;

  assign rs_idx  = IdxW'(req_q.read_slot);
  assign rs_ok   = 32'(req_q.read_slot) < 32'(TableEntries);
  assign rd_addr = (req_q.mode == ModeRead) ? rs_idx : cmd_i.idx;
  assign cur_valid = valid_q[rd_addr];
  assign age     = req_q.now - rd_q.ts;
  assign stale   = age > {16'b0, interval_q};
  assign wslot   = found_q ? hit_slot_q : (free_q ? free_slot_q : min_slot_q);
  assign wentry  = '{ts: req_q.now, sec: req_q.ent.sec, cap: req_q.ent.cap,
                     per: req_q.ent.per, sig: req_q.ent.sig, chan: req_q.ent.chan,
                     addr: req_q.ent.addr};
  assign sts_o.mode = req_q.mode;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q.mode      <= in_mode_i;
      req_q.ent.addr  <= in_data_i[47:0];
      req_q.ent.chan  <= in_data_i[55:48];
      req_q.ent.sig   <= in_data_i[63:56];
      req_q.ent.per   <= in_data_i[79:64];
      req_q.ent.cap   <= in_data_i[95:80];
      req_q.ent.sec   <= in_data_i[98:96];
      req_q.ent.ts    <= '0;
      req_q.now       <= in_data_i[146:99];
      req_q.read_slot <= in_data_i[151:147];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) mem_q[wslot] <= wentry;
    if (cmd_i.rd_en) rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      found_q <= 1'b0;
      free_q  <= 1'b0;
    end else if (cmd_i.eval && req_q.mode == ModeObserve) begin
      if (!found_q && cur_valid && rd_q.addr == req_q.ent.addr) begin
        found_q    <= 1'b1;
        hit_slot_q <= cmd_i.idx;
      end
      if (!free_q && !cur_valid) begin
        free_q      <= 1'b1;
        free_slot_q <= cmd_i.idx;
      end
      if (cmd_i.idx == '0 || $signed(rd_q.sig) < $signed(min_sig_q)) begin
        min_sig_q  <= rd_q.sig;
        min_slot_q <= cmd_i.idx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      live_q     <= '0;
      purged_q   <= '0;
      interval_q <= PurgeReset;
    end else begin
      if (cfg_we_i) interval_q <= cfg_wdata_i;
      if (cmd_i.capture) purged_q <= '0;
      if (cmd_i.eval && req_q.mode == ModePurge && cur_valid && stale) begin
        valid_q[rd_addr] <= 1'b0;
        purged_q         <= purged_q + 1'b1;
        if (live_q != '0) live_q <= live_q - 1'b1;
      end
      if (cmd_i.write) begin
        valid_q[wslot] <= 1'b1;
        if (!found_q && free_q) live_q <= live_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      res_slot_q     <= '0;
      res_present_q  <= 1'b0;
      res_replaced_q <= 1'b0;
      res_ev_q       <= 1'b0;
      res_ent_q      <= '0;
    end else if (cmd_i.write) begin
      res_slot_q     <= 5'(wslot);
      res_present_q  <= found_q;
      res_replaced_q <= !found_q && !free_q;
    end else if (cmd_i.eval && req_q.mode == ModeRead && rs_ok) begin
      res_ev_q  <= cur_valid;
      res_ent_q <= rd_q;
    end
  end

  assign live_o = live_q;
  assign out_data_o = {1'b0, res_ent_q.sec, res_ent_q.cap, res_ent_q.per, res_ent_q.sig,
                       res_ent_q.chan, res_ent_q.addr, res_ev_q, 6'(live_q), 6'(purged_q),
                       res_replaced_q, res_present_q, res_slot_q};

endmodule

FILE: rtl/core/beacon_table_with_weakest_eviction.sv
// top level of the beacon table with weakest-signal eviction
// Table of 32 access-point records keyed by station address. Each request
// takes one result; the block handles one request at a time. An observe or
// purge request walks all 32 slots through a single-port record memory, reading
// and evaluating each slot in turn; a read or no-op request evaluates only one
// slot. The user must write purge_interval via cfg_we_i only while the block is
// idle; the block itself does not enforce it. Valid marks clear at reset; no
// clearing pass is needed.
`include "beacon_table_with_weakest_eviction_macros.svh"
module beacon_table_with_weakest_eviction import btw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // station_address, radio_channel, signal_level, beacon_period,
  // capability_bits, security_code, now_time, read_slot
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // mode
  input  logic [1:0]          s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // slot_index, was_present, was_replaced, purged_count, live_count,
  // entry_valid, entry_address, entry_channel, entry_signal, entry_period,
  // entry_capability, entry_security, zero pad
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  cmd_t            cmd;
  sts_t            sts;
  logic [CntW-1:0] live;

  btw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  btw_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata_i),
    .in_mode_i   (s_axis_tuser_i),
    .out_data_o  (m_axis_tdata_o),
    .live_o      (live)
  );

  `BTW_NEVER(a_no_overlap, s_axis_tready_o && m_axis_tvalid_o)
  `BTW_NEVER(a_live_bound, 32'(live) > 32'(TableEntries))
  `BTW_ASSERT(a_busy_after_req, (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
  `BTW_ASSERT(a_ready_after_out, (m_axis_tvalid_o && m_axis_tready_i) |=> s_axis_tready_o)

endmodule
